### rtl/core/image_window_convolution_3x3_core_defines.svh
// Assertion macros shared by the 3x3 convolution core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef IMAGE_WINDOW_CONVOLUTION_3X3_CORE_DEFINES_SVH
`define IMAGE_WINDOW_CONVOLUTION_3X3_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IWC_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IWC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/iwc_pkg.sv
// Shared types and constants of the 3x3 convolution core.
// No dependencies; imported by every module of the core.
`default_nettype none

package iwc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int KSIZE      = 3;
  localparam int COEF_W     = 8;
  localparam int KERNEL_W   = KSIZE * COEF_W;
  localparam int CFG_DIM_W  = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int SUM_OUT_W   = 20;
  localparam int SUM_OUT_MAX = 524287;
  localparam int SUM_OUT_MIN = -524288;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  // Register indexes (byte address divided by four).
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KTOP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KMID   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KBOT   = 3'd4;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 11'd1024;

  typedef logic [KSIZE-1:0][KERNEL_W-1:0] krows_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    krows_t               kernel;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/iwc_cfg_regs.sv
// APB register file of the 3x3 convolution core: image size and kernel rows.
// Depends on iwc_pkg.
`default_nettype none

module iwc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iwc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [iwc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [iwc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output iwc_pkg::cfg_t                  cfg_o
);
  import iwc_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  cfg_nxt.width     = pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.height    = pwdata[CFG_DIM_W-1:0];
        REG_KTOP:   cfg_nxt.kernel[0] = pwdata[KERNEL_W-1:0];
        REG_KMID:   cfg_nxt.kernel[1] = pwdata[KERNEL_W-1:0];
        REG_KBOT:   cfg_nxt.kernel[2] = pwdata[KERNEL_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(cfg_r.width);
      REG_HEIGHT: prdata = APB_DATA_W'(cfg_r.height);
      REG_KTOP:   prdata = APB_DATA_W'(cfg_r.kernel[0]);
      REG_KMID:   prdata = APB_DATA_W'(cfg_r.kernel[1]);
      REG_KBOT:   prdata = APB_DATA_W'(cfg_r.kernel[2]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.kernel <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/iwc_line_mem.sv
// Line store of the 3x3 convolution core: one entry per column holding the
// two previous rows side by side. Synchronous, registered read. Depends on iwc_pkg.
`default_nettype none

module iwc_line_mem #(
  parameter int MAX_WIDTH  = iwc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = iwc_pkg::DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [2*PIXEL_BITS-1:0]      rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [2*PIXEL_BITS-1:0]      wr_data
);
  import iwc_pkg::*;

  localparam int DATA_W = 2 * PIXEL_BITS;

  logic [DATA_W-1:0] mem_r [MAX_WIDTH];
  logic [DATA_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  // Read-first: a read and a write to the same column in one cycle return
  // the old entry; the caller forwards the new one.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/iwc_conv_pipe.sv
// Multiply-accumulate pipeline of the 3x3 convolution core: nine products,
// three row sums, final sum with saturation and the output register. Depends on iwc_pkg.
`default_nettype none

module iwc_conv_pipe #(
  parameter int PIXEL_BITS = iwc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   win_valid,
  input  logic                                                   win_last,
  input  logic [iwc_pkg::KSIZE-1:0][iwc_pkg::KSIZE-1:0][PIXEL_BITS-1:0] win_pixels,
  input  iwc_pkg::krows_t                                        kernel_rows,
  output logic                                                   win_ready,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output logic signed [iwc_pkg::SUM_OUT_W-1:0]                   out_conv_sum,
  output logic                                                   out_end_of_frame
);
  import iwc_pkg::*;

  localparam int PROD_W = PIXEL_BITS + COEF_W + 1;
  localparam int PART_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;
  localparam int EXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SUM_OUT_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SUM_OUT_MIN);

  logic signed [PROD_W-1:0]    px_ext   [KSIZE][KSIZE];
  logic signed [PROD_W-1:0]    cf_ext   [KSIZE][KSIZE];
  logic signed [PROD_W-1:0]    prod_nxt [KSIZE][KSIZE];
  logic signed [PROD_W-1:0]    prod_r   [KSIZE][KSIZE];
  logic                        p_valid_r;
  logic                        p_last_r;

  logic signed [PART_W-1:0]    part_nxt [KSIZE];
  logic signed [PART_W-1:0]    part_r   [KSIZE];
  logic                        b_valid_r;
  logic                        b_last_r;

  logic signed [SUM_W-1:0]     total;
  logic signed [EXT_W-1:0]     total_ext;
  logic signed [SUM_OUT_W-1:0] sum_nxt;
  logic signed [SUM_OUT_W-1:0] out_sum_r;
  logic                        out_valid_r;
  logic                        out_last_r;

  logic c_free;
  logic b_free;
  logic p_free;

  assign c_free    = !out_valid_r || out_ready;
  assign b_free    = !b_valid_r || c_free;
  assign p_free    = !p_valid_r || b_free;
  assign win_ready = p_free;

  assign out_valid        = out_valid_r;
  assign out_conv_sum     = out_sum_r;
  assign out_end_of_frame = out_last_r;

  // The kernel is flipped: coefficient (kr, kc) meets pixel (2-kr, 2-kc).
  always_comb begin
    for (int kr = 0; kr < KSIZE; kr++) begin
      for (int kc = 0; kc < KSIZE; kc++) begin
        px_ext[kr][kc]   = PROD_W'({1'b0, win_pixels[KSIZE-1-kr][KSIZE-1-kc]});
        cf_ext[kr][kc]   = PROD_W'($signed(kernel_rows[kr][COEF_W*kc +: COEF_W]));
        prod_nxt[kr][kc] = px_ext[kr][kc] * cf_ext[kr][kc];
      end
    end
  end

  always_comb begin
    for (int kr = 0; kr < KSIZE; kr++) begin
      part_nxt[kr] = '0;
      for (int kc = 0; kc < KSIZE; kc++) begin
        part_nxt[kr] = part_nxt[kr] + PART_W'(prod_r[kr][kc]);
      end
    end
  end

  always_comb begin
    total     = SUM_W'(part_r[0]) + SUM_W'(part_r[1]) + SUM_W'(part_r[2]);
    total_ext = EXT_W'(total);
    if (total_ext > SAT_HI) begin
      sum_nxt = SUM_OUT_W'(SAT_HI);
    end else if (total_ext < SAT_LO) begin
      sum_nxt = SUM_OUT_W'(SAT_LO);
    end else begin
      sum_nxt = SUM_OUT_W'(total_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_valid_r <= win_valid;
      end
      if (b_free) begin
        b_valid_r <= p_valid_r;
      end
      if (c_free) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      prod_r   <= prod_nxt;
      p_last_r <= win_last;
    end
    if (b_free) begin
      part_r   <= part_nxt;
      b_last_r <= p_last_r;
    end
    if (c_free) begin
      out_sum_r  <= sum_nxt;
      out_last_r <= b_last_r;
    end
  end

endmodule

`default_nettype wire

### rtl/core/image_window_convolution_3x3_core.sv
// Top level of the 3x3 valid-region convolution core.
// Depends on iwc_pkg, iwc_cfg_regs, iwc_line_mem, iwc_conv_pipe and the defines header.
//
// Usage:
// Pixels enter in raster order on the in_ channel (valid/ready); a transfer
// with in_start_of_frame set puts that pixel at row 0, column 0. Positions
// wrap at the programmed width and height, so frames may also follow each
// other without the flag. Each pixel that completes a window around an
// interior position yields one transfer on the out_ channel carrying the
// flipped-kernel sum; out_end_of_frame marks the last result of a frame.
// Throughput is one pixel per clock unless the receiver stalls. A result passes
// the line store read, window, products, row sums and final sum registers. The
// line store is one memory with one read and one write per cycle; a write and
// a read of the same column in one cycle are resolved by forwarding. When the
// receiver stalls, the output register and the pipeline stages fill in turn
// and in_ready drops only once they are all occupied. Reset clears the position,
// the window and the pipeline and loads width 1024, height 1024 and an all-zero
// kernel; the line store is not cleared and needs no clearing pass. The user
// must write registers only while idle; the block does not enforce it.
`default_nettype none

module image_window_convolution_3x3_core #(
  parameter int MAX_WIDTH  = iwc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = iwc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [PIXEL_BITS-1:0]                in_pixel,
  input  logic                                 in_start_of_frame,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [iwc_pkg::SUM_OUT_W-1:0] out_conv_sum,
  output logic                                 out_end_of_frame,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [iwc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [iwc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [iwc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import iwc_pkg::*;

`include "image_window_convolution_3x3_core_defines.svh"

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
  localparam int MEM_W = 2 * PIXEL_BITS;

  cfg_t cfg;

  // Position tracking.
  logic [COL_W-1:0]     col_r, col_nxt, cur_col;
  logic [ROW_W-1:0]     row_r, row_nxt, cur_row;
  logic [CMP_W-1:0]     w_raw, w_eff, w_last;
  logic [CFG_DIM_W-1:0] h_eff, h_last;
  logic                 col_at_end, row_at_end;
  logic                 cur_emit, cur_last;
  logic                 in_xfer;

  // Line store access stage.
  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pixel_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_emit_r;
  logic                  s1_last_r;
  logic                  fwd_hit_r;
  logic [MEM_W-1:0]      fwd_data_r;
  logic [MEM_W-1:0]      mem_rd_data;
  logic [MEM_W-1:0]      line_word;
  logic [PIXEL_BITS-1:0] up1, up2;
  logic [MEM_W-1:0]      mem_wr_data;
  logic                  s1_adv;

  // Window stage.
  logic [KSIZE-1:0][KSIZE-1:0][PIXEL_BITS-1:0] win_r;
  logic                                        s2_valid_r;
  logic                                        s2_last_r;
  logic                                        s2_free;
  logic                                        win_ready;

  iwc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective image size, saturated into the supported range.
  always_comb begin
    w_raw = CMP_W'(cfg.width);
    if (w_raw < CMP_W'(MIN_DIM)) begin
      w_eff = CMP_W'(MIN_DIM);
    end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    w_last = w_eff - CMP_W'(1);

    if (cfg.height < CFG_DIM_W'(MIN_DIM)) begin
      h_eff = CFG_DIM_W'(MIN_DIM);
    end else if (cfg.height > CFG_DIM_W'(MAX_HEIGHT)) begin
      h_eff = CFG_DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.height;
    end
    h_last = h_eff - CFG_DIM_W'(1);
  end

  assign in_xfer    = in_valid && in_ready;
  assign cur_col    = in_start_of_frame ? '0 : col_r;
  assign cur_row    = in_start_of_frame ? '0 : row_r;
  assign col_at_end = CMP_W'(cur_col) >= w_last;
  assign row_at_end = CFG_DIM_W'(cur_row) >= h_last;
  assign cur_last   = row_at_end && col_at_end;
  assign cur_emit   = (cur_row >= ROW_W'(KSIZE - 1)) && (cur_col >= COL_W'(KSIZE - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_xfer) begin
      if (col_at_end) begin
        col_nxt = '0;
        row_nxt = row_at_end ? '0 : cur_row + ROW_W'(1);
      end else begin
        col_nxt = cur_col + COL_W'(1);
        row_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Handshake chain: each stage moves when the one after it has room.
  assign s2_free  = !s2_valid_r || win_ready;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  // Each entry holds the row two up in its upper half, the row above in its
  // lower half.
  assign line_word   = fwd_hit_r ? fwd_data_r : mem_rd_data;
  assign up2         = line_word[MEM_W-1:PIXEL_BITS];
  assign up1         = line_word[PIXEL_BITS-1:0];
  assign mem_wr_data = {up1, s1_pixel_r};

  iwc_line_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (cur_col),
    .rd_data (mem_rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // A transfer reading the column that the item in flight writes this cycle
  // takes the written word instead of the stale memory output.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= cur_col;
      s1_emit_r  <= cur_emit;
      s1_last_r  <= cur_last;
      fwd_hit_r  <= s1_valid_r && (s1_col_r == cur_col);
      fwd_data_r <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_r <= s1_valid_r && s1_emit_r;
      end
      if (s1_adv) begin
        for (int r = 0; r < KSIZE; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up2;
        win_r[1][2] <= up1;
        win_r[2][2] <= s1_pixel_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last_r <= s1_last_r;
    end
  end

  iwc_conv_pipe #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_conv (
    .clk              (clk),
    .rst_n            (rst_n),
    .win_valid        (s2_valid_r),
    .win_last         (s2_last_r),
    .win_pixels       (win_r),
    .kernel_rows      (cfg.kernel),
    .win_ready        (win_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_conv_sum     (out_conv_sum),
    .out_end_of_frame (out_end_of_frame)
  );

  `IWC_ASSERT_NEXT(a_xfer_fills_s1, clk, rst_n, in_valid && in_ready, s1_valid_r,
    "accepted pixel did not reach the line store stage")
  `IWC_ASSERT_NOW(a_s1_stall_blocks_input, clk, rst_n, s1_valid_r && !s2_free, !in_ready,
    "input accepted while the line store stage is stalled")
  `IWC_ASSERT_NOW(a_window_held_on_stall, clk, rst_n, s2_valid_r && !win_ready, !s1_adv,
    "window shifted while its result was still waiting")
  `IWC_ASSERT_NEXT(a_sof_restarts_position, clk, rst_n,
    in_valid && in_ready && in_start_of_frame, (col_r == COL_W'(1)) && (row_r == '0),
    "start of frame did not restart the position")

endmodule

`default_nettype wire

### tb/tb_image_window_convolution_3x3_core.sv
// Self-checking testbench for image_window_convolution_3x3_core.
// Raster pixel frames go in over valid/ready, kernels and sizes are set over the APB port,
// and each sum is checked against a line-store model kept here; needs only iwc_pkg and the RTL.
module tb_image_window_convolution_3x3_core;
  import iwc_pkg::*;

  localparam int PIX_W = DEF_PIXEL_BITS;
  localparam int MAX_W = DEF_MAX_WIDTH;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] sum;
    logic                        frame_end;
  } conv_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [PIX_W-1:0]            in_pixel = '0;
  logic                        in_start_of_frame = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SUM_OUT_W-1:0] out_conv_sum;
  logic                        out_end_of_frame;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]       paddr = '0;
  logic [APB_DATA_W-1:0]       pwdata = '0;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;

  image_window_convolution_3x3_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_conv_sum      (out_conv_sum),
    .out_end_of_frame  (out_end_of_frame),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the window pipeline, updated on every accepted pixel transfer.
  logic [CFG_DIM_W-1:0] cfg_width = WIDTH_RST;
  logic [CFG_DIM_W-1:0] cfg_height = HEIGHT_RST;
  logic [KERNEL_W-1:0]  kern [KSIZE];
  logic [PIX_W-1:0]     prev_row [MAX_W];
  logic [PIX_W-1:0]     older_row [MAX_W];
  logic [PIX_W-1:0]     win [KSIZE][KSIZE];
  int unsigned          col_pos = 0;
  int unsigned          row_pos = 0;
  conv_result_t         expected_sums [$];
  int                   error_count = 0;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic void convolve_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int unsigned  w, h, r, c;
    int           acc, coef_v, pix_v, kr, kc;
    logic [PIX_W-1:0] up1, up2;
    conv_result_t res;
    w = (cfg_width < MIN_DIM) ? MIN_DIM : (cfg_width > MAX_W) ? MAX_W : cfg_width;
    h = (cfg_height < MIN_DIM) ? MIN_DIM : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    up1 = prev_row[c];
    up2 = older_row[c];
    older_row[c] = up1;
    prev_row[c] = pix;
    for (kr = 0; kr < KSIZE; kr++) begin
      win[kr][0] = win[kr][1];
      win[kr][1] = win[kr][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = pix;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      // The kernel is flipped: coefficient (kr, kc) meets the pixel mirrored about the center.
      for (kr = 0; kr < KSIZE; kr++) begin
        for (kc = 0; kc < KSIZE; kc++) begin
          coef_v = $signed(kern[kr][COEF_W*kc +: COEF_W]);
          pix_v = win[2-kr][2-kc];
          acc += coef_v * pix_v;
        end
      end
      if (acc > SUM_OUT_MAX) acc = SUM_OUT_MAX;
      if (acc < SUM_OUT_MIN) acc = SUM_OUT_MIN;
      res.sum = acc[SUM_OUT_W-1:0];
      res.frame_end = (r >= h - 1) && (c >= w - 1);
      expected_sums = {expected_sums, res};
    end
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Results are checked before the pixel of the same edge is predicted, so the order is fixed.
  always @(posedge clk) begin : monitor
    conv_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("result with none pending: conv_sum %0d end_of_frame %0b",
                 out_conv_sum, out_end_of_frame);
          error_count++;
        end else begin
          want = expected_sums.pop_front();
          if (out_conv_sum !== want.sum) begin
            $error("conv_sum mismatch: expected %0d, actual %0d", want.sum, out_conv_sum);
            error_count++;
          end
          if (out_end_of_frame !== want.frame_end) begin
            $error("end_of_frame mismatch: expected %0b, actual %0b",
                   want.frame_end, out_end_of_frame);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) convolve_pixel(in_pixel, in_start_of_frame);
    end
  end

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // All tasks start and end just after a falling edge.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:  cfg_width = value[CFG_DIM_W-1:0];
      REG_HEIGHT: cfg_height = value[CFG_DIM_W-1:0];
      REG_KTOP:   kern[0] = value[KERNEL_W-1:0];
      REG_KMID:   kern[1] = value[KERNEL_W-1:0];
      REG_KBOT:   kern[2] = value[KERNEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DIM_W-1:0] w_reg, h_reg,
                           input logic [KERNEL_W-1:0] k_top, k_mid, k_bot);
    reg_write(REG_WIDTH, APB_DATA_W'(w_reg));
    reg_write(REG_HEIGHT, APB_DATA_W'(h_reg));
    reg_write(REG_KTOP, APB_DATA_W'(k_top));
    reg_write(REG_KMID, APB_DATA_W'(k_mid));
    reg_write(REG_KBOT, APB_DATA_W'(k_bot));
  endtask

  function automatic logic [KERNEL_W-1:0] pick_kernel_row();
    case ($urandom_range(0, 5))
      0:       return 24'h7F7F7F;
      1:       return 24'h808080;
      2:       return 24'h000000;
      default: return KERNEL_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_start_of_frame <= sof;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops offering pixels until every pending sum has come, then lets the pipeline settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // Smallest frames with the largest and smallest sums, and an asymmetric kernel to catch
  // a missing flip. The middle frame follows the first without a start flag.
  task automatic test_directed_kernels();
    logic [PIX_W-1:0] mixed [9] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd128, 8'd254, 8'd7, 8'd64,
                                    8'd255};
    configure(11'd3, 11'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
    drain(8);
    configure(11'd3, 11'd3, 24'h807F02, 24'hFD0405, 24'h06F980);
    for (int i = 0; i < 9; i++) send_pixel(mixed[i], 1'b0);
    drain(8);
    configure(11'd3, 11'd3, 24'h808080, 24'h808080, 24'h808080);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, i == 0);
    drain(8);
  endtask

  // Shrinks the frame while the position sits past the new bounds, so the next pixel
  // wraps both row and column and closes the frame.
  task automatic test_resize_mid_frame();
    configure(11'd8, 11'd8, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
    repeat (36) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
    drain(8);
    reg_write(REG_WIDTH, APB_DATA_W'(5));
    reg_write(REG_HEIGHT, APB_DATA_W'(3));
    repeat (31) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
    drain(8);
  endtask

  // The receiver stops for long enough that the pipeline fills and in_ready drops.
  task automatic test_output_backpressure();
    configure(11'd10, 11'd10, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    hold_request = 150;
    for (int i = 0; i < 100; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
    drain(8);
  endtask

  task automatic test_random_frames(input int phases, input int items_per_phase);
    logic [CFG_DIM_W-1:0] w_reg, h_reg;
    int  w_eff, h_eff, sent, frame_len, kind;
    bit  first, use_sof, noisy;
    for (int p = 0; p < phases; p++) begin
      w_reg = CFG_DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 12));
      h_reg = CFG_DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 8));
      configure(w_reg, h_reg, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      w_eff = (w_reg < MIN_DIM) ? MIN_DIM : w_reg;
      h_eff = (h_reg < MIN_DIM) ? MIN_DIM : h_reg;
      sent = 0;
      first = 1'b1;
      // Mostly whole frames; some cut short, some with stray start flags.
      while (sent < items_per_phase) begin
        kind = $urandom_range(0, 99);
        frame_len = w_eff * h_eff;
        if (kind >= 85 && kind < 95) frame_len = $urandom_range(1, w_eff * h_eff - 1);
        noisy = (kind >= 95);
        use_sof = first || ($urandom_range(0, 2) != 0);
        for (int i = 0; i < frame_len; i++) begin
          send_pixel(PIX_W'($urandom_range(0, 255)),
                     (i == 0 && use_sof) || (noisy && $urandom_range(0, 19) == 0));
          sent++;
          if ($urandom_range(0, 299) == 0) drain(0);
        end
        first = 1'b0;
      end
      drain(8);
    end
  endtask

  // A height register above the limit saturates to the tallest frame, so none of the
  // results of a short run may close the frame.
  task automatic test_oversized_height();
    configure(11'd5, 11'h7FF, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    for (int i = 0; i < 60; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
    drain(8);
  endtask

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      prev_row[i] = '0;
      older_row[i] = '0;
    end
    for (int i = 0; i < KSIZE; i++) kern[i] = '0;
    win = '{default: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 28;
    receiver_idle_pct = 53;
    test_directed_kernels();
    test_resize_mid_frame();
    test_random_frames(3, 170);

    sender_idle_pct = 53;
    receiver_idle_pct = 28;
    test_output_backpressure();
    test_random_frames(3, 170);
    test_oversized_height();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_frames(2, 170);

    drain(12);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/iwc_pkg.sv
rtl/core/iwc_cfg_regs.sv
rtl/core/iwc_line_mem.sv
rtl/core/iwc_conv_pipe.sv
rtl/core/image_window_convolution_3x3_core.sv
tb/tb_image_window_convolution_3x3_core.sv
